FILE: design/lagrange_interpolation_eval_defines.svh
// assertion macros used by the port-level checker file
`ifndef LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lie_pkg.sv
// package: constants, types and state codes of the lagrange evaluator
`timescale 1ns / 1ps

package lie_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int XW        = 24;
    localparam int CFG_W     = 5;
    localparam int DIFW      = 26;
    localparam int DIVW      = 80;
    localparam int DCW       = $clog2(DIVW);

    localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 5'd11;
    localparam logic [63:0]       SAT_MAG  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       TERM_CAP = 64'h4000_0000_0000_0000;
    localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN = -64'sd8388608;
    localparam logic [79:0]       F_ONE    = 80'h1_0000_0000_0000;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_SQ,
        S_LD_DIV,
        S_EV_J,
        S_EV_JR,
        S_EV_KA,
        S_EV_K,
        S_EV_NUM,
        S_EV_DEN,
        S_EV_T,
        S_EV_DIV,
        S_EV_ACC,
        S_OUT
    } lie_state_t;

    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_FIN
    } mul_ph_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [DIFW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [63:0] r;
    } mul_rsp_t;

    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] num;
        logic [63:0]     den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] q;
    } div_rsp_t;

endpackage

FILE: design/lagrange_interpolation_eval.sv
// top level: node store, evaluation sequencer and output register
//
//  channel | dir | handshake          | contents
//  cfg     | in  | cfg_wr_en          | node_count
//  s       | in  | s_tvalid/s_tready  | tuser op, tdata node_index/value
//  m       | out | m_tvalid/m_tready  | tdata interp_value, tuser saturated
//
// a load squares the value on the shared multiplier, then divides in the 80-step
// serial divider; an evaluate with n distinct nodes is paced by the shared multiplier
// (two passes per node pair) and one divide per node.
// reset clears control state and sets node_count to 11; the node store is not cleared.
// s_tready is high only while idle; a result waiting on m_tready holds the sequencer
// in its final step, and idle is reached only once the output register is free.
`timescale 1ns / 1ps

module lagrange_interpolation_eval
    import lie_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [3:0] node_index, [27:4] value, [31:28] zero
    input  logic [0:0]       s_tuser,   // [0] op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [23:0] interp_value
    output logic [0:0]       m_tuser    // [0] saturated
);

    lie_state_t state_reg, state_next;
    logic [CFG_W-1:0]        node_count_reg;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic [3:0]              slot_reg, slot_next;
    logic signed [XW-1:0]    xj_reg, xj_next;
    logic [XW-1:0]           fj_reg, fj_next;
    logic signed [XW-1:0]    xk_reg, xk_next;
    logic signed [63:0]      num_reg, num_next;
    logic signed [63:0]      den_reg, den_next;
    logic                    tneg_reg, tneg_next;
    logic [63:0]             term_reg, term_next;
    logic signed [63:0]      sum_reg, sum_next;
    logic                    sat_reg, sat_next;
    logic [23:0]             out_data_reg, out_data_next;
    logic                    out_sat_reg, out_sat_next;

    logic signed [XW-1:0]    abs_mem [MAX_NODES];
    logic [XW-1:0]           f_mem   [MAX_NODES];
    logic signed [XW-1:0]    rd_x_reg;
    logic [XW-1:0]           rd_f_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_we;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    logic                    s_acc;
    logic signed [XW-1:0]    in_value;
    logic [CNT_W-1:0]        cnt_clip;
    logic [63:0]             sq_d;
    logic [63:0]             t_mag;
    logic [63:0]             den_mag;
    logic signed [63:0]      s_term;
    logic signed [64:0]      acc_ext;

    lie_mulq u_mulq (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    lie_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_value = $signed(s_tdata[27:4]);
    assign cnt_clip = (32'(node_count_reg) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                        : CNT_W'(node_count_reg);
    assign sq_d     = 64'h1_0000_0000 + 64'(mrsp.r);
    assign t_mag    = mrsp.r[63] ? (~mrsp.r + 64'd1) : mrsp.r;
    assign den_mag  = den_reg[63] ? (~den_reg + 64'd1) : den_reg;
    assign s_term   = (tneg_reg != den_reg[63]) ? $signed(~term_reg + 64'd1)
                                                : $signed(term_reg);
    assign acc_ext  = 65'(sum_reg) + 65'(s_term);

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg;
        x_next        = x_reg;
        slot_next     = slot_reg;
        xj_next       = xj_reg;
        fj_next       = fj_reg;
        xk_next       = xk_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        tneg_next     = tneg_reg;
        term_next     = term_reg;
        sum_next      = sum_reg;
        sat_next      = sat_reg;
        out_data_next = out_data_reg;
        out_sat_next  = out_sat_reg;
        rd_en         = 1'b0;
        rd_addr       = j_reg[IDX_W-1:0];
        mem_we        = 1'b0;
        mreq          = '0;
        dreq          = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    x_next    = in_value;
                    slot_next = s_tdata[3:0];
                    if (op_t'(s_tuser[0]) == OP_LOAD)
                    begin
                        // x*x through the shared multiplier: (x<<16)*x >> 16
                        mreq.start = 1'b1;
                        mreq.a     = 64'(in_value) <<< 16;
                        mreq.b     = DIFW'(in_value);
                        state_next = S_LD_SQ;
                    end
                    else
                    begin
                        n_next     = cnt_clip;
                        j_next     = '0;
                        sum_next   = '0;
                        sat_next   = 1'b0;
                        state_next = S_EV_J;
                    end
                end
            end
            S_LD_SQ:
            begin
                if (mrsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = F_ONE + DIVW'(sq_d >> 1);
                    dreq.den   = sq_d;
                    state_next = S_LD_DIV;
                end
            end
            S_LD_DIV:
            begin
                if (drsp.done)
                begin
                    mem_we     = (32'(slot_reg) < MAX_NODES);
                    state_next = S_IDLE;
                end
            end
            S_EV_J:
            begin
                if (j_reg == n_reg)
                    state_next = S_OUT;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[IDX_W-1:0];
                    state_next = S_EV_JR;
                end
            end
            S_EV_JR:
            begin
                xj_next    = rd_x_reg;
                fj_next    = rd_f_reg;
                num_next   = Q_ONE;
                den_next   = Q_ONE;
                k_next     = '0;
                state_next = S_EV_KA;
            end
            S_EV_KA:
            begin
                if (k_reg == n_reg)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = num_reg;
                    mreq.b     = DIFW'({1'b0, fj_reg});
                    state_next = S_EV_T;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg[IDX_W-1:0];
                    state_next = S_EV_K;
                end
            end
            S_EV_K:
            begin
                // equal abscissas (the node itself or a duplicate) drop out
                if (rd_x_reg == xj_reg)
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_EV_KA;
                end
                else
                begin
                    xk_next    = rd_x_reg;
                    mreq.start = 1'b1;
                    mreq.a     = num_reg;
                    mreq.b     = DIFW'(x_reg) - DIFW'(rd_x_reg);
                    state_next = S_EV_NUM;
                end
            end
            S_EV_NUM:
            begin
                if (mrsp.done)
                begin
                    num_next   = mrsp.r;
                    sat_next   = sat_reg | mrsp.sat;
                    mreq.start = 1'b1;
                    mreq.a     = den_reg;
                    mreq.b     = DIFW'(xj_reg) - DIFW'(xk_reg);
                    state_next = S_EV_DEN;
                end
            end
            S_EV_DEN:
            begin
                if (mrsp.done)
                begin
                    den_next   = mrsp.r;
                    sat_next   = sat_reg | mrsp.sat;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_EV_KA;
                end
            end
            S_EV_T:
            begin
                if (mrsp.done)
                begin
                    tneg_next = mrsp.r[63];
                    sat_next  = sat_reg | mrsp.sat;
                    if (den_reg == '0)
                    begin
                        sat_next   = 1'b1;
                        term_next  = (t_mag == '0) ? 64'd0 : TERM_CAP;
                        state_next = S_EV_ACC;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.num   = {t_mag, 16'h0000};
                        dreq.den   = den_mag;
                        state_next = S_EV_DIV;
                    end
                end
            end
            S_EV_DIV:
            begin
                if (drsp.done)
                begin
                    term_next  = drsp.q;
                    sat_next   = sat_reg | drsp.sat;
                    state_next = S_EV_ACC;
                end
            end
            S_EV_ACC:
            begin
                if (acc_ext[64] != acc_ext[63])
                begin
                    sat_next = 1'b1;
                    sum_next = acc_ext[64] ? SUM_MIN : SUM_MAX;
                end
                else
                    sum_next = acc_ext[63:0];
                j_next     = j_reg + CNT_W'(1);
                state_next = S_EV_J;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    if (sum_reg > OUT_MAX)
                    begin
                        out_data_next = OUT_MAX[23:0];
                        out_sat_next  = 1'b1;
                    end
                    else if (sum_reg < OUT_MIN)
                    begin
                        out_data_next = OUT_MIN[23:0];
                        out_sat_next  = 1'b1;
                    end
                    else
                    begin
                        out_data_next = sum_reg[23:0];
                        out_sat_next  = sat_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            n_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                node_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        slot_reg     <= slot_next;
        xj_reg       <= xj_next;
        fj_reg       <= fj_next;
        xk_reg       <= xk_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        tneg_reg     <= tneg_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        sat_reg      <= sat_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    // node store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            abs_mem[slot_reg[IDX_W-1:0]] <= x_reg;
            f_mem[slot_reg[IDX_W-1:0]]   <= drsp.q[XW-1:0];
        end
        if (rd_en)
        begin
            rd_x_reg <= abs_mem[rd_addr];
            rd_f_reg <= f_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

FILE: design/lie_mulq.sv
// saturating q32.32 by q.16 multiply on one shared 32x26 multiplier, in high, low and final phases
`timescale 1ns / 1ps

module lie_mulq
    import lie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                busy_reg;
    mul_ph_t             ph_reg;
    logic                done_reg;
    logic [63:0]         ua_reg;
    logic [DIFW-1:0]     ub_reg;
    logic                neg_reg;
    logic [57:0]         hi_reg;
    logic [57:0]         lo_reg;
    logic signed [63:0]  r_reg;
    logic                sat_reg;
    logic [31:0]         mul_a;
    logic [57:0]         prod;
    logic [63:0]         r_sum;
    logic [63:0]         r_mag;
    logic                sat_c;

    assign mul_a = (ph_reg == PH_HI) ? ua_reg[63:32] : ua_reg[31:0];
    assign prod  = 58'(mul_a) * 58'(ub_reg);

    always_comb
    begin
        r_sum = {1'b0, hi_reg[46:0], 16'h0000} + 64'(lo_reg[57:16]);
        sat_c = 1'b0;
        r_mag = r_sum;
        if (|hi_reg[57:47])
        begin
            sat_c = 1'b1;
            r_mag = SAT_MAG;
        end
        else if (r_sum[63])
        begin
            sat_c = 1'b1;
            r_mag = SAT_MAG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_HI;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= PH_HI;
            end
            else if (busy_reg)
            begin
                case (ph_reg)
                    PH_HI:   ph_reg <= PH_LO;
                    PH_LO:   ph_reg <= PH_FIN;
                    PH_FIN:
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        ph_reg   <= PH_HI;
                    end
                    default: ph_reg <= PH_HI;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ua_reg  <= req.a[63] ? (~req.a + 64'd1) : req.a;
            ub_reg  <= req.b[DIFW-1] ? (~req.b + DIFW'(1)) : req.b;
            neg_reg <= req.a[63] ^ req.b[DIFW-1];
        end
        if (busy_reg && ph_reg == PH_HI)
            hi_reg <= prod;
        if (busy_reg && ph_reg == PH_LO)
            lo_reg <= prod;
        if (busy_reg && ph_reg == PH_FIN)
        begin
            r_reg   <= neg_reg ? $signed(~r_mag + 64'd1) : $signed(r_mag);
            sat_reg <= sat_c;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.r    = r_reg;

endmodule

FILE: design/lie_div.sv
// restoring bit-serial divider, one quotient bit per cycle, quotient capped at 2^62
`timescale 1ns / 1ps

module lie_div
    import lie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic            busy_reg;
    logic [DCW-1:0]  cnt_reg;
    logic            done_reg;
    logic [DIVW-1:0] n_reg;
    logic [63:0]     d_reg;
    logic [63:0]     rem_reg;
    logic [63:0]     q_reg;
    logic            ovf_reg;
    logic            sat_reg;
    logic [64:0]     rem_sh;
    logic            ge;
    logic [64:0]     diff;
    logic [63:0]     q_n;
    logic            ovf_n;
    logic            cap_c;

    always_comb
    begin
        rem_sh = {rem_reg, n_reg[DIVW-1]};
        ge     = rem_sh >= {1'b0, d_reg};
        diff   = rem_sh - {1'b0, d_reg};
        q_n    = {q_reg[62:0], ge};
        ovf_n  = ovf_reg | (|q_reg[63:62]);
        cap_c  = ovf_n || (q_n > TERM_CAP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCW'(DIVW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg   <= req.num;
            d_reg   <= req.den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIVW-2:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : rem_sh[63:0];
            q_reg   <= q_n;
            ovf_reg <= ovf_n;
            if (cnt_reg == '0)
            begin
                q_reg   <= cap_c ? TERM_CAP : q_n;
                sat_reg <= cap_c;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.q    = q_reg;

endmodule

FILE: design/lie_checker.sv
// port-level checker for the lagrange evaluator, bound to the top level
`timescale 1ns / 1ps
`include "lagrange_interpolation_eval_defines.svh"

module lie_checker
    import lie_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic s_acc;
    logic load_acc;

    assign s_acc    = s_tvalid && s_tready;
    assign load_acc = s_acc && (op_t'(s_tuser[0]) == OP_LOAD);

    // every transaction makes the block busy in the cycle after it
    `LIE_ASSERT_NEXT(a_busy_after_acc, s_acc, !s_tready, "ready right after a transaction")
    // a result only shows up as the sequencer returns to idle
    `LIE_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), $past(!s_tready),
        "result appeared while idle")
    // a load produces no result
    `LIE_ASSERT_NEXT(a_load_no_result, load_acc && !m_tvalid, !m_tvalid,
        "result after a load")
    // a stalled result holds
    `LIE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind lagrange_interpolation_eval lie_checker u_lie_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/tb_lagrange_interpolation_eval.sv
// testbench for the lagrange evaluator: directed, then random load/evaluate stream against a scoreboard
`timescale 1ns / 1ps

class interp_scoreboard;
    localparam int MAX_NODES_TB = lie_pkg::MAX_NODES;

    typedef struct {
        logic [23:0] interp_value;
        logic        saturated;
    } interp_result_t;

    logic signed [23:0] abscissa [MAX_NODES_TB];
    logic [23:0]        fvalue [MAX_NODES_TB];
    logic [4:0]         node_count;
    interp_result_t     pending [$];
    int                 mismatches;
    int                 loads_seen;
    int                 evals_seen;
    int                 results_checked;
    int                 saturated_seen;

    function new();
        node_count = lie_pkg::NODE_COUNT_RST;
        mismatches = 0;
        loads_seen = 0;
        evals_seen = 0;
        results_checked = 0;
        saturated_seen = 0;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    // 1/(1+x^2) in q.16, rounded half up
    function automatic logic [23:0] runge_value(input logic signed [23:0] x);
        logic [63:0] ux;
        logic [63:0] d;
        logic [63:0] q;
        ux = magnitude(64'(x));
        d = (64'd1 << 32) + ux * ux;
        q = ((64'd1 << 48) + (d >> 1)) / d;
        return q[23:0];
    endfunction

    // q32.32 times q.16, truncated toward zero, saturating symmetrically
    function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic sat);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        logic        neg;
        ua = magnitude(a);
        ub = magnitude(b);
        neg = (a < 0) != (b < 0);
        hi = (ua >> 32) * ub;
        lo = (ua & 64'hFFFF_FFFF) * ub;
        if (hi >= (64'd1 << 47))
        begin
            sat = 1'b1;
            r = lie_pkg::SAT_MAG;
        end
        else
        begin
            r = (hi << 16) + (lo >> 16);
            if (r > lie_pkg::SAT_MAG)
            begin
                sat = 1'b1;
                r = lie_pkg::SAT_MAG;
            end
        end
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic interp_result_t interpolate(input logic signed [23:0] query);
        interp_result_t     res;
        logic signed [63:0] sum;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [63:0] t;
        logic signed [63:0] s;
        logic signed [65:0] acc;
        logic [63:0]        ut;
        logic [63:0]        ud;
        logic [63:0]        term;
        logic [79:0]        quot;
        logic               sat;
        int                 n;
        sum = 0;
        sat = 1'b0;
        n = (node_count > MAX_NODES_TB) ? MAX_NODES_TB : int'(node_count);
        for (int j = 0; j < n; j++)
        begin
            num = lie_pkg::Q_ONE;
            den = lie_pkg::Q_ONE;
            for (int k = 0; k < n; k++)
            begin
                if (abscissa[k] == abscissa[j])
                    continue;
                num = mul_q(num, 64'(query) - 64'(abscissa[k]), sat);
                den = mul_q(den, 64'(abscissa[j]) - 64'(abscissa[k]), sat);
            end
            t = mul_q(num, $signed({40'd0, fvalue[j]}), sat);
            ut = magnitude(t);
            ud = magnitude(den);
            if (ud == 0)
            begin
                // basis denominator truncated away
                sat = 1'b1;
                term = (ut == 0) ? 64'd0 : lie_pkg::TERM_CAP;
            end
            else
            begin
                quot = {ut, 16'd0} / {16'd0, ud};
                if (quot > {16'd0, lie_pkg::TERM_CAP})
                begin
                    sat = 1'b1;
                    term = lie_pkg::TERM_CAP;
                end
                else
                    term = quot[63:0];
            end
            s = ((t < 0) != (den < 0)) ? -$signed(term) : $signed(term);
            acc = 66'(sum) + 66'(s);
            if (acc > 66'(lie_pkg::SUM_MAX))
            begin
                sat = 1'b1;
                sum = lie_pkg::SUM_MAX;
            end
            else if (acc < 66'(lie_pkg::SUM_MIN))
            begin
                sat = 1'b1;
                sum = lie_pkg::SUM_MIN;
            end
            else
                sum = acc[63:0];
        end
        if (sum > lie_pkg::OUT_MAX)
        begin
            sat = 1'b1;
            sum = lie_pkg::OUT_MAX;
        end
        else if (sum < lie_pkg::OUT_MIN)
        begin
            sat = 1'b1;
            sum = lie_pkg::OUT_MIN;
        end
        res.interp_value = sum[23:0];
        res.saturated = sat;
        return res;
    endfunction

    function void set_count(input logic [4:0] count);
        node_count = count;
    endfunction

    function void note_input(input lie_pkg::op_t op, input logic [3:0] slot,
                             input logic signed [23:0] value);
        if (op == lie_pkg::OP_LOAD)
        begin
            abscissa[slot] = value;
            fvalue[slot] = runge_value(value);
            loads_seen++;
        end
        else
        begin
            pending.insert(pending.size(), interpolate(value));
            evals_seen++;
        end
    endfunction

    function void check_result(input logic [23:0] data, input logic sat);
        interp_result_t exp_res;
        results_checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: value %h saturated %b", data, sat);
            return;
        end
        exp_res = pending.pop_front();
        if (sat)
            saturated_seen++;
        if (data !== exp_res.interp_value || sat !== exp_res.saturated)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value %h saturated %b, got value %h saturated %b",
                         exp_res.interp_value, exp_res.saturated, data, sat);
        end
    endfunction
endclass

module tb_lagrange_interpolation_eval;
    import lie_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [3:0] node_index, [27:4] value, [31:28] zero
    logic [0:0]  s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [23:0] interp_value
    logic [0:0]  m_tuser;   // [0] saturated

    interp_scoreboard sb;
    int               items_sent;
    int               max_src_gap;
    int               max_sink_gap;
    int               phase_count;

    lagrange_interpolation_eval dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input op_t op, input logic [3:0] slot,
                             input logic signed [23:0] value);
        int gap;
        gap = $urandom_range(0, max_src_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, value, slot};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, slot, value);
        items_sent++;
    endtask

    // wait for the block to go idle, then write node_count
    task automatic write_count(input logic [4:0] count);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_count(count);
        phase_count++;
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'($signed($urandom_range(0, 524288)) - 262144);
            4, 5:       return 24'($urandom);
            6, 7:       return sb.abscissa[$urandom_range(0, MAX_NODES - 1)];
            8:          return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default:    return 24'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // result side: random backpressure per transaction
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, max_sink_gap);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [4:0] count;
        int         phase_len;
        int         evals_left;
        logic signed [23:0] directed_nodes [16];
        sb = new();
        items_sent = 0;
        phase_count = 0;
        max_src_gap = 5;
        max_sink_gap = 5;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, exact one, duplicates and tiny spacings
        directed_nodes = '{24'sd0, 24'sh7FFFFF, 24'sh800000, 24'sd65536, -24'sd65536,
                           24'sd65536, 24'sd1, -24'sd1, 24'sd131072, 24'sd32768,
                           -24'sd131072, 24'sd2, 24'sd196608, -24'sd32768,
                           24'sd262144, 24'sh7FFFFE};
        for (int i = 0; i < 16; i++)
            send_item(OP_LOAD, 4'(i), directed_nodes[i]);
        send_item(OP_EVAL, 4'd0, 24'sd0);
        send_item(OP_EVAL, 4'd15, 24'sh7FFFFF);
        send_item(OP_EVAL, 4'd5, 24'sh800000);
        send_item(OP_EVAL, 4'd9, 24'sd65536);
        write_count(5'd0);
        send_item(OP_EVAL, 4'd0, 24'sd12345);
        write_count(5'd31);
        send_item(OP_EVAL, 4'd0, 24'sd98304);
        write_count(5'd16);
        send_item(OP_EVAL, 4'd0, -24'sd40000);
        write_count(5'd1);
        send_item(OP_EVAL, 4'd0, 24'sd65536);

        // random phases: mostly small node sets, occasionally the full store
        while (items_sent < 1300)
        begin
            case ($urandom_range(0, 19))
                0:       count = 5'd0;
                1:       count = 5'd16;
                2:       count = 5'($urandom_range(17, 31));
                3, 4:    count = 5'($urandom_range(7, 10));
                default: count = 5'($urandom_range(1, 6));
            endcase
            write_count(count);
            max_src_gap = $urandom_range(0, 3) == 0 ? 0 : 5;
            max_sink_gap = $urandom_range(0, 3) == 0 ? 0 : 5;
            phase_len = $urandom_range(20, 40);
            evals_left = (count > 8) ? 3 : phase_len;
            for (int i = 0; i < phase_len; i++)
            begin
                if (evals_left > 0 && $urandom_range(0, 9) < 4)
                begin
                    send_item(OP_EVAL, 4'($urandom), pick_value());
                    evals_left--;
                end
                else if ($urandom_range(0, 4) != 0 && count > 0 && count <= 16)
                    send_item(OP_LOAD, 4'($urandom_range(0, count - 1)), pick_value());
                else
                    send_item(OP_LOAD, 4'($urandom), pick_value());
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d loads and %0d evaluations over %0d node-count settings",
                 sb.loads_seen, sb.evals_seen, phase_count);
        $display("checked %0d results, %0d saturated, %0d mismatches",
                 sb.results_checked, sb.saturated_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
